[rtl/core/chpc_pkg.sv]
// Shared types and constants for the convex hull plane cull unit.
// Used by the front end, the queue, the back end and the top level.
// No dependencies.
`default_nettype none

package chpc_pkg;

	localparam int PLANE_SLOTS = 6;   // most planes the unit can ever hold
	localparam int VERT_W      = 16;  // Q8.8 vertex coordinate
	localparam int COEF_W      = 16;  // Q1.14 normal component or Q8.8 offset
	localparam int PROD_W      = 32;  // coefficient times coordinate
	localparam int SUM_W       = 34;  // exact sum of three products and the offset
	localparam int D_SHIFT     = 14;  // aligns the Q8.8 offset to 22 fraction bits
	localparam int IN_W        = 48;  // packed vertex on the input stream
	localparam int OUT_W       = 8;   // result byte on the output stream
	localparam int CNT_W       = 3;   // plane count register
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int QDEPTH      = 4;   // classification queue depth
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] plane_t;

	// Register indexes of the configuration port.
	localparam cfg_idx_t CFG_PLANE_COUNT = 3'd0;
	localparam cfg_idx_t CFG_PLANE_BASE  = 3'd1;

	// One classified vertex: which planes it lies on or in front of.
	typedef struct packed {
		logic [PLANE_SLOTS-1:0] hit;
		logic                   last;
	} q_entry_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	typedef struct packed {
		logic busy_s1;
		logic busy_s2;
	} fe_stat_t;

endpackage

`default_nettype wire

[rtl/core/chpc_front.sv]
// Front end: accepts vertices and tests each one against every plane.
// Two stages (products, then sum and sign); pushes into the queue.
// Depends on chpc_pkg.
`default_nettype none

module chpc_front #(
	parameter int MAX_PLANES = 6
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire chpc_pkg::plane_t            planes [MAX_PLANES],
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [chpc_pkg::IN_W-1:0]   s_tdata,
	input  wire logic                        s_tlast,
	input  wire logic [chpc_pkg::QCNT_W-1:0] q_count,
	output logic                             push,
	output chpc_pkg::q_entry_t               entry,
	output chpc_pkg::fe_stat_t               fe_stat
);
	import chpc_pkg::*;

	logic                     valid_s1, valid_s2;
	logic                     last_s1, last_s2;
	logic [QCNT_W:0]          inflight;
	logic                     accept;
	logic signed [VERT_W-1:0] vx, vy, vz;
	logic [PLANE_SLOTS-1:0]   hit;
	logic [PLANE_SLOTS-1:0]   hit_s2;

	// Space is reserved in the queue for every vertex still in the pipe.
	always_comb begin
		inflight = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(valid_s1) + (QCNT_W+1)'(valid_s2);
		s_tready = inflight < (QCNT_W+1)'(QDEPTH);
		accept   = s_tvalid & s_tready;
		vx       = $signed(s_tdata[VERT_W-1:0]);
		vy       = $signed(s_tdata[2*VERT_W-1:VERT_W]);
		vz       = $signed(s_tdata[3*VERT_W-1:2*VERT_W]);
	end

	for (genvar j = 0; j < PLANE_SLOTS; j++) begin : g_plane
		if (j < MAX_PLANES) begin : g_used
			logic signed [COEF_W-1:0] ca, cb, cc;
			logic signed [PROD_W-1:0] pa_s1, pb_s1, pc_s1;
			logic signed [COEF_W-1:0] d_s1;
			logic signed [SUM_W-1:0]  sum;

			assign ca = $signed(planes[j][COEF_W-1:0]);
			assign cb = $signed(planes[j][2*COEF_W-1:COEF_W]);
			assign cc = $signed(planes[j][3*COEF_W-1:2*COEF_W]);

			always_ff @(posedge clk) begin
				pa_s1 <= ca * vx;
				pb_s1 <= cb * vy;
				pc_s1 <= cc * vz;
				d_s1  <= $signed(planes[j][4*COEF_W-1:3*COEF_W]);
			end

			always_comb begin
				sum = SUM_W'(pa_s1) + SUM_W'(pb_s1) + SUM_W'(pc_s1)
					+ (SUM_W'(d_s1) <<< D_SHIFT);
			end

			assign hit[j] = ~sum[SUM_W-1];
		end else begin : g_unused
			assign hit[j] = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		hit_s2 <= hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= s_tlast;
		last_s2 <= last_s1;
	end

	assign push            = valid_s2;
	assign entry.hit       = hit_s2;
	assign entry.last      = last_s2;
	assign fe_stat.busy_s1 = valid_s1;
	assign fe_stat.busy_s2 = valid_s2;

endmodule

`default_nettype wire

[rtl/core/chpc_queue.sv]
// Short queue of classified vertices between the front and back ends.
// Register array with read and write pointers. Depends on chpc_pkg.
`default_nettype none

module chpc_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire chpc_pkg::q_entry_t wr_entry,
	input  wire logic               pop,
	output chpc_pkg::q_entry_t      head,
	output chpc_pkg::q_stat_t       stat
);
	import chpc_pkg::*;

	q_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == QCNT_W'(QDEPTH));

endmodule

`default_nettype wire

[rtl/core/chpc_back.sv]
// Back end: folds per-vertex plane hits into the touched flags and
// delivers the verdict on the last vertex through an output register.
// Depends on chpc_pkg.
`default_nettype none

module chpc_back #(
	parameter int MAX_PLANES = 6
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire chpc_pkg::q_entry_t         head,
	input  wire chpc_pkg::q_stat_t          q_stat,
	input  wire logic [chpc_pkg::CNT_W-1:0] plane_count,
	output logic                            pop,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [chpc_pkg::OUT_W-1:0]      m_tdata
);
	import chpc_pkg::*;

	logic [PLANE_SLOTS-1:0] touched_q;
	logic [PLANE_SLOTS-1:0] merged;
	logic [PLANE_SLOTS-1:0] mask;
	logic [CNT_W-1:0]       active;
	logic                   slot_free;
	logic                   m_valid_q;
	logic                   visible_q;

	always_comb begin
		active = (plane_count > CNT_W'(MAX_PLANES)) ? CNT_W'(MAX_PLANES) : plane_count;
		for (int j = 0; j < PLANE_SLOTS; j++) begin
			mask[j] = CNT_W'(j) < active;
		end
		merged    = touched_q | head.hit;
		slot_free = !m_valid_q || m_tready;
		pop       = !q_stat.empty && (!head.last || slot_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touched_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				touched_q <= head.last ? '0 : merged;
			end
			if (pop && head.last) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			visible_q <= ((merged & mask) == mask);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(OUT_W-1)'(0), visible_q};

endmodule

`default_nettype wire

[rtl/core/convex_hull_plane_cull_unit.sv]
// Convex hull plane cull unit: culls a streamed point set against up to six planes.
// Throughput is one vertex per cycle while the queue has room; the per-plane
// tests run in parallel in a two-stage front end (multipliers, then the exact sum
// and its sign). After its last vertex is accepted, a result passes the two front
// stages, the queue and the output register, waiting while the output is full.
// Reset clears the plane registers, the plane count, the touched flags and the queue.
`default_nettype none

module convex_hull_plane_cull_unit #(
	parameter int MAX_PLANES = 6
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Vertex stream. s_tdata: vert_x [15:0], vert_y [31:16], vert_z [47:32].
	// s_tlast carries last_vertex.
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [chpc_pkg::IN_W-1:0]       s_tdata,
	input  wire logic                            s_tlast,
	// Result stream. m_tdata: visible [0], zeros above.
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [chpc_pkg::OUT_W-1:0]           m_tdata,
	// Configuration writes: index 0 is the plane count, 1 to 6 are planes 0 to 5.
	input  wire logic                            cfg_we,
	input  wire logic [chpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [chpc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import chpc_pkg::*;

	// Configuration registers. A write to an index with no register is dropped.
	// Each plane packs a, b, c (Q1.14) and d (Q8.8) from the low 16 bits up.
	logic [CNT_W-1:0] plane_count_q;
	plane_t           plane_q [MAX_PLANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_count_q <= '0;
		end else if (cfg_we && cfg_index == CFG_PLANE_COUNT) begin
			plane_count_q <= cfg_data[CNT_W-1:0];
		end
	end

	for (genvar j = 0; j < MAX_PLANES; j++) begin : g_plane_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				plane_q[j] <= '0;
			end else if (cfg_we && cfg_index == CFG_PLANE_BASE + CFG_IDX_W'(j)) begin
				plane_q[j] <= cfg_data;
			end
		end
	end

	// The front end classifies each vertex and pushes one queue entry per beat.
	// It holds s_tready low whenever the queue could not take every vertex
	// already in its pipeline, so it never has to stall internally.
	q_entry_t fe_entry;
	q_entry_t q_head;
	q_stat_t  q_stat;
	fe_stat_t fe_stat;
	logic     fe_push;
	logic     be_pop;

	chpc_front #(
		.MAX_PLANES(MAX_PLANES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.planes   (plane_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_count  (q_stat.count),
		.push     (fe_push),
		.entry    (fe_entry),
		.fe_stat  (fe_stat)
	);

	chpc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fe_push),
		.wr_entry (fe_entry),
		.pop      (be_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	// The back end drains non-last entries freely and takes a last entry only
	// when the output register is empty or being emptied in the same cycle.
	// The plane count is sampled when the last vertex is folded in.
	chpc_back #(
		.MAX_PLANES(MAX_PLANES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.q_stat      (q_stat),
		.plane_count (plane_count_q),
		.pop         (be_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	// The front end must never push into a full queue unless the back end pops.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fe_push |-> (!q_stat.full || be_pop))
		else $error("classification queue overflow");

	// Queued entries plus vertices in flight never exceed the queue depth.
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		((QCNT_W+1)'(q_stat.count) + (QCNT_W+1)'(fe_stat.busy_s1)
			+ (QCNT_W+1)'(fe_stat.busy_s2)) <= (QCNT_W+1)'(QDEPTH))
		else $error("front end outran its queue credit");

	// Folding in a last vertex always loads a result beat.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(be_pop && q_head.last) |=> m_tvalid)
		else $error("last vertex produced no result");

	// Popping requires a queued entry.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		be_pop |-> !q_stat.empty)
		else $error("classification queue underflow");

endmodule

`default_nettype wire

[tb/convex_hull_plane_cull_checker.sv]
// Scoreboard for the convex hull plane cull unit: watches the config port and both streams,
// predicts the visibility of each volume and compares it with the result beats.
// Depends on chpc_pkg for widths, register indexes and the plane type.
module convex_hull_plane_cull_checker #(
	parameter int MAX_PLANES = 6
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	input  wire logic                            s_tready,
	input  wire logic [chpc_pkg::IN_W-1:0]       s_tdata,
	input  wire logic                            s_tlast,
	input  wire logic                            m_tvalid,
	input  wire logic                            m_tready,
	input  wire logic [chpc_pkg::OUT_W-1:0]      m_tdata,
	input  wire logic                            cfg_we,
	input  wire logic [chpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [chpc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                   fail_count,
	output int                                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import chpc_pkg::*;

	logic [CNT_W-1:0]       plane_count_q;
	plane_t                 plane_q [PLANE_SLOTS];
	logic [PLANE_SLOTS-1:0] touched_q;
	logic                   visible_q [$];
	int                     mismatches = 0;

	// Exact signed test a*x + b*y + c*z + d*2^14 >= 0 with 22 fraction bits.
	function automatic logic plane_sees_vertex(plane_t pl, logic signed [VERT_W-1:0] x,
			logic signed [VERT_W-1:0] y, logic signed [VERT_W-1:0] z);
		longint acc;
		acc = longint'($signed(pl[15:0])) * x + longint'($signed(pl[31:16])) * y
			+ longint'($signed(pl[47:32])) * z + longint'($signed(pl[63:48])) * 16384;
		return acc >= 0;
	endfunction

	// A count above the plane limit behaves as the limit itself.
	function automatic logic volume_visible(logic [CNT_W-1:0] count,
			logic [PLANE_SLOTS-1:0] seen);
		int active;
		active = (count > MAX_PLANES) ? MAX_PLANES : count;
		for (int j = 0; j < active; j++) begin
			if (!seen[j]) return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [PLANE_SLOTS-1:0] seen;
		logic                   want;
		if (!arst_n) begin
			plane_count_q = '0;
			foreach (plane_q[i]) plane_q[i] = '0;
			touched_q = '0;
			visible_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_PLANE_COUNT) begin
					plane_count_q = cfg_data[CNT_W-1:0];
				end else if (cfg_index >= CFG_PLANE_BASE
						&& cfg_index < CFG_PLANE_BASE + PLANE_SLOTS) begin
					plane_q[cfg_index - CFG_PLANE_BASE] = cfg_data;
				end
			end
			if (s_tvalid && s_tready) begin
				seen = touched_q;
				for (int j = 0; j < MAX_PLANES; j++) begin
					if (plane_sees_vertex(plane_q[j], s_tdata[15:0], s_tdata[31:16],
							s_tdata[47:32]))
						seen[j] = 1'b1;
				end
				if (s_tlast) begin
					visible_q.push_back(volume_visible(plane_count_q, seen));
					touched_q = '0;
				end else begin
					touched_q = seen;
				end
			end
			if (m_tvalid && m_tready) begin
				if (visible_q.size() == 0) begin
					mismatches++;
					$display("%0t: result beat %h arrived with no volume pending", $time,
						m_tdata);
				end else begin
					want = visible_q.pop_front();
					if (m_tdata[0] !== want) begin
						mismatches++;
						$display("%0t: visible expected %0b actual %b", $time, want, m_tdata[0]);
					end
					if (m_tdata[OUT_W-1:1] !== '0) begin
						mismatches++;
						$display("%0t: padding expected 0 actual %b", $time,
							m_tdata[OUT_W-1:1]);
					end
				end
			end
		end
		fail_count  <= mismatches;
		outstanding <= visible_q.size();
	end

endmodule

[tb/tb_convex_hull_plane_cull_unit.sv]
// Top of the plane cull testbench: clock, reset, config writes, vertex stimulus and verdict.
// Depends on chpc_pkg, the convex_hull_plane_cull_unit RTL and convex_hull_plane_cull_checker.
module tb_convex_hull_plane_cull_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import chpc_pkg::*;

	localparam int MAX_PLANES      = 6;
	localparam int ITEMS_PER_PHASE = 150;
	// Margin after the last result so that register writes land on an idle block.
	localparam int SETTLE_CYCLES   = 8;

	// One index past the plane registers: writes there must have no effect.
	localparam cfg_idx_t CFG_UNMAPPED = cfg_idx_t'(CFG_PLANE_BASE + PLANE_SLOTS);

	localparam logic [15:0] ONE_Q14     = 16'h4000;  // +1.0 in Q1.14
	localparam logic [15:0] NEG_ONE_Q14 = 16'hC000;  // -1.0 in Q1.14
	localparam logic [15:0] ONE_Q8      = 16'h0100;  // +1.0 in Q8.8

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata   = '0;
	logic                 s_tlast   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_we    = 1'b0;
	cfg_idx_t             cfg_index = '0;
	plane_t               cfg_data  = '0;

	int fail_count;
	int outstanding;

	// Percentages of cycles in which the vertex source idles and the result sink stalls.
	int send_idle  = 0;
	int recv_stall = 0;

	convex_hull_plane_cull_unit #(
		.MAX_PLANES(MAX_PLANES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // vert_x [15:0], vert_y [31:16], vert_z [47:32]
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // visible [0], zeros above
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	convex_hull_plane_cull_checker #(
		.MAX_PLANES(MAX_PLANES)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// The result sink decides each cycle afresh whether it can take a beat.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall);
	end

	// Hard stop in case the block hangs; far beyond the slowest correct run.
	initial begin
		#400_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic plane_t pack_plane(logic [15:0] a, logic [15:0] b, logic [15:0] c,
			logic [15:0] d);
		return {d, c, b, a};
	endfunction

	// A third of the planes are raw random bits; the rest face along one axis with a
	// random offset, biased toward offsets that let clustered volumes through.
	function automatic plane_t random_plane();
		logic [15:0] n_x, n_y, n_z, off, dir;
		int          axis;
		if ($urandom_range(0, 2) == 0) return {$urandom, $urandom};
		n_x  = '0;
		n_y  = '0;
		n_z  = '0;
		dir  = $urandom_range(0, 1) ? ONE_Q14 : NEG_ONE_Q14;
		axis = $urandom_range(0, 2);
		case (axis)
			0: n_x = dir;
			1: n_y = dir;
			default: n_z = dir;
		endcase
		off = $urandom_range(0, 1) ? 16'($urandom_range(0, 32767)) : 16'($urandom);
		return pack_plane(n_x, n_y, n_z, off);
	endfunction

	// All drive tasks are entered just after a rising edge and return just after one.
	task automatic write_reg(cfg_idx_t idx, plane_t value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one vertex beat, after a random number of idle cycles, and returns on the
	// edge that accepts it. Valid stays high across back-to-back beats.
	task automatic push_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic last);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {z, y, x};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Stops the source until every predicted result has come out, then lets the pipeline
	// settle so that register writes land on an idle block.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One bounding volume of 1 to 8 corners: either spread over the whole range or
	// clustered within +/-1.0 of a random center, so that box planes both pass and cull it.
	task automatic random_volume(output int sent);
		int          n;
		logic        spread;
		logic [15:0] cx, cy, cz;
		n      = $urandom_range(1, 8);
		spread = ($urandom_range(0, 3) == 0);
		cx     = 16'($urandom);
		cy     = 16'($urandom);
		cz     = 16'($urandom);
		for (int i = 0; i < n; i++) begin
			if (spread) begin
				push_vertex(16'($urandom), 16'($urandom), 16'($urandom), i == n - 1);
			end else begin
				push_vertex(16'(cx + $urandom_range(0, 511) - 256),
					16'(cy + $urandom_range(0, 511) - 256),
					16'(cz + $urandom_range(0, 511) - 256), i == n - 1);
			end
		end
		sent = n;
	endtask

	// Unit box of half size 1.0 around the origin, one plane per face.
	task automatic load_unit_box();
		write_reg(cfg_idx_t'(CFG_PLANE_BASE + 0), pack_plane(ONE_Q14, 0, 0, ONE_Q8));
		write_reg(cfg_idx_t'(CFG_PLANE_BASE + 1), pack_plane(NEG_ONE_Q14, 0, 0, ONE_Q8));
		write_reg(cfg_idx_t'(CFG_PLANE_BASE + 2), pack_plane(0, ONE_Q14, 0, ONE_Q8));
		write_reg(cfg_idx_t'(CFG_PLANE_BASE + 3), pack_plane(0, NEG_ONE_Q14, 0, ONE_Q8));
		write_reg(cfg_idx_t'(CFG_PLANE_BASE + 4), pack_plane(0, 0, ONE_Q14, ONE_Q8));
		write_reg(cfg_idx_t'(CFG_PLANE_BASE + 5), pack_plane(0, 0, NEG_ONE_Q14, ONE_Q8));
	endtask

	initial begin
		int sent;
		int budget;
		int setting;
		int count;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Straight after reset no plane is active, so any vertex is visible.
		push_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
		wait_idle();

		load_unit_box();
		write_reg(CFG_PLANE_COUNT, 6);
		push_vertex(16'h0000, 16'h0000, 16'h0000, 1'b1);   // center of the box
		push_vertex(ONE_Q8, 16'h0000, 16'h0000, 1'b1);     // exactly on a face counts as in
		push_vertex(16'h0101, 16'h0000, 16'h0000, 1'b1);   // just outside one face
		// A volume whose corners are each outside but which straddles the box.
		push_vertex(16'h0200, 16'h0000, 16'h0000, 1'b0);
		push_vertex(16'hFE00, 16'h0000, 16'h0000, 1'b1);
		// Two corners outside the same face: culled.
		push_vertex(16'h0200, 16'h0200, 16'h0000, 1'b0);
		push_vertex(16'h0200, 16'h0000, 16'h0200, 1'b1);
		// Coordinate extremes.
		push_vertex(16'h8000, 16'h8000, 16'h8000, 1'b1);
		push_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
		wait_idle();

		// A count above the plane limit saturates to the limit.
		write_reg(CFG_PLANE_COUNT, 7);
		push_vertex(16'h0101, 16'h0000, 16'h0000, 1'b1);
		push_vertex(16'h0000, 16'h0000, 16'h0000, 1'b1);
		wait_idle();

		// Only plane 0 is active; the failing flag of plane 1 must not matter.
		write_reg(CFG_PLANE_COUNT, 1);
		push_vertex(16'h0200, 16'h0000, 16'h0000, 1'b1);
		push_vertex(16'hFD00, 16'h0000, 16'h0000, 1'b1);
		wait_idle();

		// Registers change between two corners of one volume: the second corner is tested
		// against the moved face, and the count is taken when the last corner arrives.
		write_reg(CFG_PLANE_COUNT, 6);
		push_vertex(16'h0200, 16'h0000, 16'h0000, 1'b0);
		wait_idle();
		write_reg(cfg_idx_t'(CFG_PLANE_BASE + 1), pack_plane(NEG_ONE_Q14, 0, 0, 16'h0300));
		write_reg(CFG_PLANE_COUNT, 2);
		push_vertex(16'h0200, 16'h0000, 16'h0000, 1'b1);
		wait_idle();

		// A write past the last plane register leaves everything as it was.
		write_reg(CFG_UNMAPPED, '1);
		push_vertex(16'h0000, 16'h0000, 16'h0000, 1'b1);
		wait_idle();

		// Coefficient extremes: all ones, most negative and most positive in every field.
		write_reg(cfg_idx_t'(CFG_PLANE_BASE + 0), '1);
		write_reg(cfg_idx_t'(CFG_PLANE_BASE + 1), {4{16'h8000}});
		write_reg(cfg_idx_t'(CFG_PLANE_BASE + 2), {4{16'h7FFF}});
		write_reg(CFG_PLANE_COUNT, 3);
		push_vertex(16'h8000, 16'h8000, 16'h8000, 1'b1);
		push_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
		push_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);
		push_vertex(16'hFFFF, 16'h0001, 16'hFFFF, 1'b1);

		// Random part: four flow-control phases, each with three register settings. The
		// count cycles through zero, the limit, above the limit and values in between.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle  = 0;
					recv_stall = 0;
				end
				1: begin
					send_idle  = 56;
					recv_stall = 0;
				end
				2: begin
					send_idle  = 0;
					recv_stall = 56;
				end
				default: begin
					send_idle  = 11;
					recv_stall = 11;
				end
			endcase
			for (int k = 0; k < 3; k++) begin
				setting = phase * 3 + k;
				case (setting % 4)
					0: count = 6;
					1: count = 0;
					2: count = 7;
					default: count = $urandom_range(1, 5);
				endcase
				wait_idle();
				write_reg(CFG_PLANE_COUNT, count);
				for (int p = 0; p < PLANE_SLOTS; p++) begin
					write_reg(cfg_idx_t'(CFG_PLANE_BASE + p), random_plane());
				end
				budget = ITEMS_PER_PHASE / 3;
				while (budget > 0) begin
					// Now and then hold the source until the output has fully drained.
					if ($urandom_range(0, 39) == 0) wait_idle();
					random_volume(sent);
					budget -= sent;
				end
			end
		end

		wait_idle();
		if (fail_count == 0 && outstanding == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
